### rtl/dcmn_pkg.sv
// Shared types and constants for the depth colormap normalizer.
`timescale 1ns / 1ps
`default_nettype none
package dcmn_pkg;

  localparam int unsigned DepthW = 16;
  localparam int unsigned FixW   = 17;  // Q1.16, 1.0 = 65536
  localparam int unsigned ByteW  = 8;

  localparam logic [FixW-1:0]  FixOne     = 17'd65536;
  localparam logic signed [19:0] FixOneHalf = 20'sd98304;
  localparam logic signed [19:0] FixTwo     = 20'sd131072;
  localparam logic [DepthW-1:0] DepthMinReset = 16'hFFFF;
  localparam logic [DepthW-1:0] DepthMaxReset = 16'h0000;

  typedef enum logic [1:0] {
    ACT_CLEAR    = 2'd0,
    ACT_MEASURE  = 2'd1,
    ACT_COLORIZE = 2'd2,
    ACT_NONE     = 2'd3
  } action_t;

  // How the back end derives n for one colorize job.
  typedef enum logic [1:0] {
    JOB_BLACK  = 2'd0,  // black pixel
    JOB_LOW    = 2'd1,  // n = 0
    JOB_HIGH   = 2'd2,  // n = 1
    JOB_DIVIDE = 2'd3   // n = (diff << 16) / range, diff < range
  } job_mode_t;

  typedef struct packed {
    job_mode_t         mode;
    logic [DepthW-1:0] diff;
    logic [DepthW-1:0] range;
  } job_t;

  function automatic logic [FixW-1:0] clamp_unit(input logic signed [19:0] t);
    logic [FixW-1:0] res;
    if (t < 0) begin
      res = '0;
    end else if (t > $signed({3'b000, FixOne})) begin
      res = FixOne;
    end else begin
      res = t[FixW-1:0];
    end
    return res;
  endfunction

  function automatic logic [ByteW-1:0] to_byte(input logic [FixW-1:0] t);
    logic [24:0] prod;
    prod = ({8'd0, t} << 8) - {8'd0, t} + 25'd32768;
    return prod[23:16];
  endfunction

endpackage
`default_nettype wire

### rtl/depth_colormap_minmax_normalizer.sv
// Top level of the depth colormap normalizer.
`timescale 1ns / 1ps
`default_nettype none
// Colorizes 16-bit depth samples with a jet-like palette after min/max
// normalization. Stream a clear item, then the frame as measure items, then
// the frame again as colorize items; each colorize item yields one RGB pixel,
// clear and measure items yield nothing. Clear and measure items are taken
// one per clock while full is low. A colorize item that needs a real
// division passes the bit-serial divider, then the palette mapping; items
// that resolve to black, zero or full scale skip the divider. A two-entry
// job queue lets the front keep taking items while the back end is
// dividing; full rises once that queue holds two colorize jobs.
module depth_colormap_minmax_normalizer (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        push,
  output logic                             full,
  input  wire logic [1:0]                  in_action,
  input  wire logic [dcmn_pkg::DepthW-1:0] in_depth,
  output logic                             empty,
  input  wire logic                        pop,
  output logic [dcmn_pkg::ByteW-1:0]       out_red,
  output logic [dcmn_pkg::ByteW-1:0]       out_green,
  output logic [dcmn_pkg::ByteW-1:0]       out_blue
);

  logic           accept;
  logic           job_push;
  dcmn_pkg::job_t job_in;
  dcmn_pkg::job_t job_out;
  logic           q_full;
  logic           q_empty;
  logic           q_pop;

  // Take any item while the job queue has room.
  assign full   = q_full;
  assign accept = push && !q_full;

  dcmn_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .action   (in_action),
    .depth    (in_depth),
    .job_push (job_push),
    .job      (job_in)
  );

  dcmn_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (job_push),
    .wr_job  (job_in),
    .q_full  (q_full),
    .rd_en   (q_pop),
    .rd_job  (job_out),
    .q_empty (q_empty)
  );

  dcmn_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .job     (job_out),
    .q_pop   (q_pop),
    .pop     (pop),
    .empty   (empty),
    .red     (out_red),
    .green   (out_green),
    .blue    (out_blue)
  );

  // Never write into a full queue.
  assert property (@(posedge clk) disable iff (!rst_n) !(job_push && q_full))
    else $error("job queue overflow");

  // Never take a job from an empty queue.
  assert property (@(posedge clk) disable iff (!rst_n) !(q_pop && q_empty))
    else $error("job queue underflow");

  // A waiting pixel that is not taken stays put.
  assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_red) && $stable(out_green)
                          && $stable(out_blue)))
    else $error("pending pixel lost or changed");

endmodule
`default_nettype wire

### rtl/dcmn_front.sv
// Front end: min/max statistics and classification of colorize items.
`timescale 1ns / 1ps
`default_nettype none
module dcmn_front (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        accept,
  input  wire logic [1:0]                  action,
  input  wire logic [dcmn_pkg::DepthW-1:0] depth,
  output logic                             job_push,
  output dcmn_pkg::job_t                   job
);

  logic [dcmn_pkg::DepthW-1:0] min_r, min_nxt;
  logic [dcmn_pkg::DepthW-1:0] max_r, max_nxt;
  logic [dcmn_pkg::DepthW-1:0] range;
  logic [dcmn_pkg::DepthW-1:0] diff;

  always_comb begin
    min_nxt = min_r;
    max_nxt = max_r;
    if (accept) begin
      case (dcmn_pkg::action_t'(action))
        dcmn_pkg::ACT_CLEAR: begin
          min_nxt = dcmn_pkg::DepthMinReset;
          max_nxt = dcmn_pkg::DepthMaxReset;
        end
        dcmn_pkg::ACT_MEASURE: begin
          if (depth != '0) begin
            if (depth < min_r) min_nxt = depth;
            if (depth > max_r) max_nxt = depth;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r <= dcmn_pkg::DepthMinReset;
      max_r <= dcmn_pkg::DepthMaxReset;
    end else begin
      min_r <= min_nxt;
      max_r <= max_nxt;
    end
  end

  // Classify against the statistics as they stand before this item.
  assign range = (max_r > min_r) ? (max_r - min_r) : dcmn_pkg::DepthW'(1);
  assign diff  = depth - min_r;

  always_comb begin
    job.diff  = diff;
    job.range = range;
    if (depth == '0 || max_r == '0) begin
      job.mode = dcmn_pkg::JOB_BLACK;
    end else if (depth <= min_r) begin
      job.mode = dcmn_pkg::JOB_LOW;
    end else if (diff >= range) begin
      job.mode = dcmn_pkg::JOB_HIGH;
    end else begin
      job.mode = dcmn_pkg::JOB_DIVIDE;
    end
  end

  assign job_push = accept && (dcmn_pkg::action_t'(action) == dcmn_pkg::ACT_COLORIZE);

endmodule
`default_nettype wire

### rtl/dcmn_queue.sv
// Two-entry job queue between front and back end.
`timescale 1ns / 1ps
`default_nettype none
module dcmn_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           wr_en,
  input  wire dcmn_pkg::job_t wr_job,
  output logic                q_full,
  input  wire logic           rd_en,
  output dcmn_pkg::job_t      rd_job,
  output logic                q_empty
);

  dcmn_pkg::job_t mem_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wr_ptr_r] <= wr_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (wr_en) wr_ptr_r <= ~wr_ptr_r;
      if (rd_en) rd_ptr_r <= ~rd_ptr_r;
      count_r <= count_r + {1'b0, wr_en} - {1'b0, rd_en};
    end
  end

  assign rd_job  = mem_r[rd_ptr_r];
  assign q_full  = count_r[1];
  assign q_empty = (count_r == 2'd0);

endmodule
`default_nettype wire

### rtl/dcmn_back.sv
// Back end: serial divider for n, palette mapping and result register.
`timescale 1ns / 1ps
`default_nettype none
module dcmn_back (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       q_empty,
  input  wire dcmn_pkg::job_t             job,
  output logic                            q_pop,
  input  wire logic                       pop,
  output logic                            empty,
  output logic [dcmn_pkg::ByteW-1:0]      red,
  output logic [dcmn_pkg::ByteW-1:0]      green,
  output logic [dcmn_pkg::ByteW-1:0]      blue
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_MAP
  } state_t;

  state_t                       state_r;
  logic [dcmn_pkg::DepthW-1:0]  rem_r;
  logic [dcmn_pkg::DepthW-1:0]  range_r;
  logic [dcmn_pkg::DepthW-1:0]  quo_r;
  logic [3:0]                   step_r;
  logic [dcmn_pkg::FixW-1:0]    n_r;
  logic                         black_r;
  logic                         out_valid_r;
  logic [dcmn_pkg::ByteW-1:0]   red_r, green_r, blue_r;

  logic [dcmn_pkg::DepthW:0]    trial;
  logic [dcmn_pkg::DepthW:0]    trial_sub;
  logic                         fits;
  logic                         slot_free;
  logic                         load_px;
  logic signed [19:0]           s;
  logic signed [19:0]           mid_gap;
  logic signed [19:0]           mid_gap_abs;

  assign trial     = {rem_r, 1'b0};
  assign trial_sub = trial - {1'b0, range_r};
  assign fits      = trial >= {1'b0, range_r};
  assign slot_free = !out_valid_r || pop;
  assign load_px   = (state_r == ST_MAP) && slot_free;
  assign q_pop     = (state_r == ST_IDLE) && !q_empty;

  assign s           = $signed({1'b0, n_r, 2'b00});
  assign mid_gap     = s - dcmn_pkg::FixTwo;
  assign mid_gap_abs = (mid_gap < 0) ? -mid_gap : mid_gap;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (load_px) begin
        out_valid_r <= 1'b1;
      end else if (pop) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (!q_empty) begin
            rem_r   <= job.diff;
            range_r <= job.range;
            step_r  <= '0;
            black_r <= (job.mode == dcmn_pkg::JOB_BLACK);
            n_r     <= (job.mode == dcmn_pkg::JOB_HIGH) ? dcmn_pkg::FixOne : '0;
            state_r <= (job.mode == dcmn_pkg::JOB_DIVIDE) ? ST_DIV : ST_MAP;
          end
        end
        ST_DIV: begin
          // One quotient bit per cycle, restoring.
          rem_r  <= fits ? trial_sub[dcmn_pkg::DepthW-1:0] : trial[dcmn_pkg::DepthW-1:0];
          quo_r  <= {quo_r[dcmn_pkg::DepthW-2:0], fits};
          step_r <= step_r + 4'd1;
          if (step_r == 4'd15) begin
            n_r     <= {1'b0, quo_r[dcmn_pkg::DepthW-2:0], fits};
            state_r <= ST_MAP;
          end
        end
        ST_MAP: begin
          if (slot_free) begin
            if (black_r) begin
              red_r   <= '0;
              green_r <= '0;
              blue_r  <= '0;
            end else begin
              red_r   <= dcmn_pkg::to_byte(dcmn_pkg::clamp_unit(s - dcmn_pkg::FixOneHalf));
              green_r <= dcmn_pkg::to_byte(
                           dcmn_pkg::clamp_unit(dcmn_pkg::FixOneHalf - mid_gap_abs));
              blue_r  <= dcmn_pkg::to_byte(dcmn_pkg::clamp_unit(dcmn_pkg::FixOneHalf - s));
            end
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign empty = !out_valid_r;
  assign red   = red_r;
  assign green = green_r;
  assign blue  = blue_r;

endmodule
`default_nettype wire

### bench/tb_top.sv
// Self-checking bench for the depth colormap normalizer: directed, back-pressure and random frames.
`timescale 1ns / 1ps
module tb_top;

  // Clock and reset; inputs change on the falling edge.
  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  logic push = 1'b0;
  logic full;
  logic [1:0] in_action = dcmn_pkg::ACT_NONE;
  logic [dcmn_pkg::DepthW-1:0] in_depth = '0;
  logic empty;
  logic pop = 1'b0;
  logic [dcmn_pkg::ByteW-1:0] out_red, out_green, out_blue;

  depth_colormap_minmax_normalizer u_top (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full),
    .in_action(in_action), .in_depth(in_depth),
    .empty(empty), .pop(pop),
    .out_red(out_red), .out_green(out_green), .out_blue(out_blue)
  );

  typedef struct packed {
    logic [dcmn_pkg::ByteW-1:0] red;
    logic [dcmn_pkg::ByteW-1:0] green;
    logic [dcmn_pkg::ByteW-1:0] blue;
  } pixel_t;

  // Predictor state: running statistics of nonzero measured samples.
  logic [dcmn_pkg::DepthW-1:0] stat_min = 16'hFFFF;
  logic [dcmn_pkg::DepthW-1:0] stat_max = 16'h0000;
  pixel_t pending_pixels[$];

  int errors = 0;
  int items_sent = 0;
  int pixels_checked = 0;
  int idle_cycles = 0;
  bit hold_pop = 1'b0;
  int hold_len = 0;

  // Map a Q1.16 value in [0,1] to a byte, rounding halves up.
  function automatic logic [dcmn_pkg::ByteW-1:0] fix_to_byte(input longint t);
    longint c;
    c = (t < 0) ? 0 : ((t > 65536) ? 65536 : t);
    return dcmn_pkg::ByteW'((c * 255 + 32768) >> 16);
  endfunction

  function automatic pixel_t colorize_pixel(input logic [dcmn_pkg::DepthW-1:0] d);
    pixel_t p;
    longint rng, n, s, dv, q;
    p = '0;
    if (d == 0 || stat_max == 0) return p;
    rng = (stat_max > stat_min) ? (stat_max - stat_min) : 1;
    if (d <= stat_min) begin
      n = 0;
    end else begin
      q = ((longint'(d) - stat_min) << 16) / rng;
      n = (q > 65536) ? 65536 : q;
    end
    s = n * 4;
    dv = s - 131072;
    if (dv < 0) dv = -dv;
    p.red = fix_to_byte(s - 98304);
    p.green = fix_to_byte(98304 - dv);
    p.blue = fix_to_byte(98304 - s);
    return p;
  endfunction

  // Update the prediction for an accepted item.
  function automatic void predict_item(input logic [1:0] act,
                                       input logic [dcmn_pkg::DepthW-1:0] d);
    case (act)
      dcmn_pkg::ACT_CLEAR: begin
        stat_min = 16'hFFFF;
        stat_max = 16'h0000;
      end
      dcmn_pkg::ACT_MEASURE: begin
        if (d != 0) begin
          if (d < stat_min) stat_min = d;
          if (d > stat_max) stat_max = d;
        end
      end
      dcmn_pkg::ACT_COLORIZE: pending_pixels.push_back(colorize_pixel(d));
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(input string what);
    errors++;
    $display("MISMATCH at %0t: %s", $time, what);
  endtask

  // Offer one item after a random gap; hold it until accepted.
  // Push stays high afterwards so the next item can follow back to back.
  task automatic send_item(input logic [1:0] act, input logic [dcmn_pkg::DepthW-1:0] d,
                           input bit no_gap = 1'b0);
    int gap;
    gap = no_gap ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14));
    if ($urandom_range(0, 2) == 0) gap = 0;
    @(negedge clk);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    push <= 1'b1;
    in_action <= act;
    in_depth <= d;
    do @(posedge clk); while (full);
    predict_item(act, d);
    items_sent++;
  endtask

  // Receiver: random stalls, plus a long hold-off on request.
  initial begin : receiver
    int wait_n;
    forever begin
      @(negedge clk);
      if (hold_pop) begin
        pop <= 1'b0;
        repeat (hold_len) @(negedge clk);
        hold_pop = 1'b0;
      end
      wait_n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 14) : 0;
      if (wait_n > 0) begin
        pop <= 1'b0;
        repeat (wait_n) @(negedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
    end
  end

  // Check each accepted pixel against the oldest expectation.
  always @(posedge clk) begin
    pixel_t exp_px;
    if (rst_n && pop && !empty) begin
      if (pending_pixels.size() == 0) begin
        report_mismatch("pixel with no expectation");
      end else begin
        exp_px = pending_pixels.pop_front();
        pixels_checked++;
        if (out_red !== exp_px.red)
          report_mismatch($sformatf("red %0d exp %0d", out_red, exp_px.red));
        if (out_green !== exp_px.green)
          report_mismatch($sformatf("green %0d exp %0d", out_green, exp_px.green));
        if (out_blue !== exp_px.blue)
          report_mismatch($sformatf("blue %0d exp %0d", out_blue, exp_px.blue));
      end
    end
  end

  // Watchdog: count cycles without any accepted item or pixel.
  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 5000) begin
      $display("Watchdog expired");
      $display("Regression FAIL");
      $finish;
    end
  end

  // Drop push and wait until every expected pixel has come back.
  task automatic drain_pixels();
    @(negedge clk);
    push <= 1'b0;
    while (pending_pixels.size() != 0) @(negedge clk);
  endtask

  // Extremes, every action, and each corner of the palette.
  task automatic run_directed();
    send_item(dcmn_pkg::ACT_COLORIZE, 16'd500);     // no statistics yet: black
    send_item(dcmn_pkg::ACT_MEASURE, 16'd0);        // zero ignored
    send_item(dcmn_pkg::ACT_COLORIZE, 16'd0);       // zero depth: black
    send_item(dcmn_pkg::ACT_NONE, 16'hFFFF);        // unused code: ignored
    send_item(dcmn_pkg::ACT_MEASURE, 16'd1);
    send_item(dcmn_pkg::ACT_MEASURE, 16'hFFFF);
    send_item(dcmn_pkg::ACT_COLORIZE, 16'd1);
    send_item(dcmn_pkg::ACT_COLORIZE, 16'hFFFF);
    send_item(dcmn_pkg::ACT_COLORIZE, 16'h8000);
    send_item(dcmn_pkg::ACT_COLORIZE, 16'h4000);
    send_item(dcmn_pkg::ACT_COLORIZE, 16'hC000);
    send_item(dcmn_pkg::ACT_COLORIZE, 16'h5555);
    send_item(dcmn_pkg::ACT_CLEAR, 16'h0);
    send_item(dcmn_pkg::ACT_MEASURE, 16'd1000);     // equal min and max
    send_item(dcmn_pkg::ACT_COLORIZE, 16'd1000);
    send_item(dcmn_pkg::ACT_COLORIZE, 16'd1001);
    send_item(dcmn_pkg::ACT_COLORIZE, 16'd999);
    send_item(dcmn_pkg::ACT_MEASURE, 16'd2000);
    send_item(dcmn_pkg::ACT_COLORIZE, 16'd10);      // below minimum
    send_item(dcmn_pkg::ACT_COLORIZE, 16'd60000);   // above maximum
    send_item(dcmn_pkg::ACT_COLORIZE, 16'd1500);
    drain_pixels();
  endtask

  // Random frames: usually a clear, then a measure pass and a colorize pass, with occasional noise.
  task automatic run_random_frames(input int budget);
    logic [dcmn_pkg::DepthW-1:0] frame[$];
    int sz;
    logic [dcmn_pkg::DepthW-1:0] base, span;
    while (budget > 0) begin
      sz = $urandom_range(1, 12);
      base = dcmn_pkg::DepthW'($urandom);
      span = ($urandom_range(0, 1)) ? dcmn_pkg::DepthW'($urandom_range(0, 64))
                                    : dcmn_pkg::DepthW'($urandom);
      frame.delete();
      for (int i = 0; i < sz; i++) begin
        if ($urandom_range(0, 7) == 0) frame.push_back('0);
        else frame.push_back(dcmn_pkg::DepthW'(base + ($urandom % (span + 1))));
      end
      if ($urandom_range(0, 9) != 0)
        send_item(dcmn_pkg::ACT_CLEAR, dcmn_pkg::DepthW'($urandom));
      foreach (frame[i]) send_item(dcmn_pkg::ACT_MEASURE, frame[i]);
      if ($urandom_range(0, 5) == 0)
        send_item(dcmn_pkg::ACT_NONE, dcmn_pkg::DepthW'($urandom));
      foreach (frame[i]) send_item(dcmn_pkg::ACT_COLORIZE, frame[i]);
      // Noise: stray colorize of arbitrary depth.
      if ($urandom_range(0, 3) == 0)
        send_item(dcmn_pkg::ACT_COLORIZE, dcmn_pkg::DepthW'($urandom));
      budget -= 2 * sz + 1;
    end
  endtask

  // Hold the receiver off while the sender floods colorize items.
  task automatic run_backpressure();
    hold_len = 300;
    hold_pop = 1'b1;
    send_item(dcmn_pkg::ACT_CLEAR, 16'd0, 1'b1);
    send_item(dcmn_pkg::ACT_MEASURE, 16'd100, 1'b1);
    send_item(dcmn_pkg::ACT_MEASURE, 16'd40000, 1'b1);
    for (int i = 0; i < 12; i++)
      send_item(dcmn_pkg::ACT_COLORIZE, dcmn_pkg::DepthW'($urandom), 1'b1);
    drain_pixels();
  endtask

  initial begin
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    run_directed();
    run_backpressure();
    run_random_frames(200);
    drain_pixels();  // sender pauses until every pixel is back
    run_random_frames(230);
    drain_pixels();
    repeat (40) @(negedge clk);
    $display("Covered %0d items across directed, stalled and random frames;", items_sent);
    $display("%0d pixels compared, %0d mismatches.", pixels_checked, errors);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
